// File: design/xcpd_pkg.sv
package xcpd_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned SLOT_CNT_W = 5;
  localparam int unsigned TABLE_W    = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // A frame size is a length byte plus two, so it needs one bit more than a byte.
  localparam int unsigned PSIZE_W = BYTE_W + 1;

  // Results produced by one received byte are capped at this count.
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned RUN_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [BYTE_W-1:0] CHK_INIT = 8'h00;

  // Defaults of the top level parameters.
  localparam int unsigned BUF_DEPTH_DEF       = 64;
  localparam int unsigned MIN_FRAME_BYTES_DEF = 5;
  localparam int unsigned DEVICE_SLOTS_DEF    = 16;

  // Reset values of the configuration registers.
  localparam logic [LEN_W-1:0]      MIN_LEN_RST   = 6'd3;
  localparam logic [LEN_W-1:0]      MAX_LEN_RST   = 6'd62;
  localparam logic [TABLE_W-1:0]    TABLE_RST     = '0;
  localparam logic [SLOT_CNT_W-1:0] SLOT_CNT_RST  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN   = 3'd0,
    CFG_MAX_LEN   = 3'd1,
    CFG_TABLE_LO  = 3'd2,
    CFG_TABLE_HI  = 3'd3,
    CFG_DST_SLOTS = 3'd4,
    CFG_SRC_SLOTS = 3'd5
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;         // store the received byte
    logic rd_start;   // restart reading at the candidate start
    logic rd_next;    // read the next byte of the candidate
    logic cap_src;
    logic cap_len;
    logic cap_dst;
    logic chk_clr;
    logic chk_acc;
    logic head_inc;   // give up the candidate start by one byte
    logic head_add;   // step over an emitted frame
    logic commit;     // drop consumed bytes from the buffer
    logic out_load;   // present the byte just read
    logic pend_load;  // hold back the check byte of a frame
    logic pend_out;   // present the held check byte
    logic pend_last;  // the held check byte closes the run
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few;          // fewer than the minimum bytes left
    logic len_bad;
    logic src_ok;
    logic dst_ok;
    logic frame_short;  // candidate frame not yet complete
    logic at_last;      // the byte just read is the frame's last
    logic chk_ok;
    logic over_limit;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// File: design/xcpd_datapath.sv
module xcpd_datapath #(
  parameter int unsigned BUF_DEPTH       = xcpd_pkg::BUF_DEPTH_DEF,
  parameter int unsigned MIN_FRAME_BYTES = xcpd_pkg::MIN_FRAME_BYTES_DEF,
  parameter int unsigned DEVICE_SLOTS    = xcpd_pkg::DEVICE_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [xcpd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [xcpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [xcpd_pkg::BYTE_W-1:0]       rx_byte_i,
  input  logic                              out_ready_i,
  input  xcpd_pkg::cmd_t                    cmd_i,
  output xcpd_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  output logic [xcpd_pkg::BYTE_W-1:0]       frame_byte_o,
  output logic [xcpd_pkg::POS_W-1:0]        byte_position_o,
  output logic                              frame_end_o,
  output logic                              run_end_o
);
  import xcpd_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned CW = $clog2(BUF_DEPTH + 1);
  localparam int unsigned OW = CW + 1;
  localparam int unsigned WW = ((CW > PSIZE_W) ? CW : PSIZE_W) + 2;

  // Configuration registers.
  logic [LEN_W-1:0]      min_len_q, max_len_q;
  logic [TABLE_W-1:0]    tbl_lo_q, tbl_hi_q;
  logic [SLOT_CNT_W-1:0] dst_cnt_q, src_cnt_q;

  // Hunt buffer, kept as a ring: base_q is where the oldest byte lives.
  logic [BYTE_W-1:0] hunt_buf_q [BUF_DEPTH];
  logic [AW-1:0]     base_q;
  logic [CW-1:0]     fill_q, head_q, ptr_q, ptr_d;
  logic [BYTE_W-1:0] rd_data_q;
  logic [AW-1:0]     rd_addr, wr_addr;

  logic [BYTE_W-1:0] src_q, len_q, dst_q, chk_q;
  logic [RUN_W-1:0]  n_q;

  logic              pend_valid_q;
  logic [BYTE_W-1:0] pend_byte_q;
  logic [POS_W-1:0]  pend_pos_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_end_q, out_run_q;

  logic [PSIZE_W-1:0]       psize;
  logic [CW-1:0]            avail;
  logic [2*TABLE_W-1:0]     tbl;
  logic                     src_ok, dst_ok, full;

  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                             input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = (OW+1)'(base) + (OW+1)'(off);
    if (sum >= (OW+1)'(BUF_DEPTH)) begin
      sum = sum - (OW+1)'(BUF_DEPTH);
    end
    return AW'(sum);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
      tbl_lo_q  <= TABLE_RST;
      tbl_hi_q  <= TABLE_RST;
      dst_cnt_q <= SLOT_CNT_RST;
      src_cnt_q <= SLOT_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_LEN:   min_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_MAX_LEN:   max_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_TABLE_LO:  tbl_lo_q  <= cfg_data_i[TABLE_W-1:0];
        CFG_TABLE_HI:  tbl_hi_q  <= cfg_data_i[TABLE_W-1:0];
        CFG_DST_SLOTS: dst_cnt_q <= cfg_data_i[SLOT_CNT_W-1:0];
        CFG_SRC_SLOTS: src_cnt_q <= cfg_data_i[SLOT_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tbl   = {tbl_hi_q, tbl_lo_q};
  assign psize = PSIZE_W'(len_q) + PSIZE_W'(2);
  assign avail = fill_q - head_q;
  assign full  = (OW'(fill_q) >= OW'(BUF_DEPTH));

  // Slots beyond the implemented count never match, which also clamps a
  // slot count that is set too large.
  always_comb begin
    src_ok = 1'b0;
    dst_ok = 1'b0;
    for (int i = 0; i < DEVICE_SLOTS; i++) begin
      if ((i < int'(src_cnt_q)) && (tbl[8*i +: 8] == src_q)) begin
        src_ok = 1'b1;
      end
      if ((i < int'(dst_cnt_q)) && (tbl[8*i +: 8] == dst_q)) begin
        dst_ok = 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd_i.rd_start) begin
      ptr_d = '0;
    end else if (cmd_i.rd_next) begin
      ptr_d = ptr_q + CW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  assign rd_addr = ring_idx(base_q, OW'(head_q) + OW'(ptr_d));
  assign wr_addr = ring_idx(base_q, OW'(fill_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && !full) begin
      hunt_buf_q[wr_addr] <= rx_byte_i;
    end
    rd_data_q <= hunt_buf_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_src) begin
      src_q <= rd_data_q;
    end
    if (cmd_i.cap_len) begin
      len_q <= rd_data_q;
    end
    if (cmd_i.cap_dst) begin
      dst_q <= rd_data_q;
    end
    if (cmd_i.chk_clr) begin
      chk_q <= CHK_INIT;
    end else if (cmd_i.chk_acc) begin
      chk_q <= chk_q ^ rd_data_q;
    end
    if (cmd_i.pend_load) begin
      pend_byte_q <= rd_data_q;
      pend_pos_q  <= POS_W'(ptr_q);
    end
    if (cmd_i.out_load) begin
      out_byte_q <= rd_data_q;
      out_pos_q  <= POS_W'(ptr_q);
      out_end_q  <= 1'b0;
      out_run_q  <= 1'b0;
    end else if (cmd_i.pend_out) begin
      out_byte_q <= pend_byte_q;
      out_pos_q  <= pend_pos_q;
      out_end_q  <= 1'b1;
      out_run_q  <= cmd_i.pend_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      fill_q       <= '0;
      head_q       <= '0;
      ptr_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      if (cmd_i.wr && !full) begin
        fill_q <= fill_q + CW'(1);
      end else if (cmd_i.commit) begin
        fill_q <= fill_q - head_q;
      end
      if (cmd_i.commit) begin
        base_q <= ring_idx(base_q, OW'(head_q));
        head_q <= '0;
        n_q    <= '0;
      end else if (cmd_i.head_inc) begin
        head_q <= head_q + CW'(1);
      end else if (cmd_i.head_add) begin
        head_q <= head_q + CW'(psize);
        n_q    <= n_q + RUN_W'(psize);
      end
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.pend_out) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.out_load || cmd_i.pend_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.few         = WW'(avail) < WW'(MIN_FRAME_BYTES);
    status_o.len_bad     = (len_q < BYTE_W'(min_len_q)) || (len_q > BYTE_W'(max_len_q)) ||
                           (WW'(psize) > WW'(BUF_DEPTH));
    status_o.src_ok      = src_ok;
    status_o.dst_ok      = dst_ok;
    status_o.frame_short = WW'(avail) < WW'(psize);
    status_o.at_last     = (WW'(ptr_q) + WW'(1)) == WW'(psize);
    status_o.chk_ok      = (chk_q == rd_data_q);
    status_o.over_limit  = (WW'(n_q) + WW'(psize)) > WW'(MAX_RESULTS);
    status_o.pend_valid  = pend_valid_q;
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign frame_end_o     = out_end_q;
  assign run_end_o       = out_run_q;

endmodule

// File: design/xcpd_ctrl.sv
module xcpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xcpd_pkg::status_t status_i,
  output xcpd_pkg::cmd_t    cmd_o
);
  import xcpd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SRC,
    ST_LEN,
    ST_DST,
    ST_EVAL,
    ST_CHK,
    ST_PEND,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.rd_start = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_start = 1'b1;
        state_d        = status_i.few ? ST_FLUSH : ST_SRC;
      end
      ST_SRC: begin
        cmd_o.cap_src = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = ST_LEN;
      end
      ST_LEN: begin
        cmd_o.cap_len = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = ST_DST;
      end
      ST_DST: begin
        cmd_o.cap_dst = 1'b1;
        state_d       = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.rd_start = 1'b1;
        if (status_i.len_bad || !status_i.src_ok || !status_i.dst_ok) begin
          cmd_o.head_inc = 1'b1;
          state_d        = ST_SCAN;
        end else if (status_i.frame_short) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.chk_clr = 1'b1;
          state_d       = ST_CHK;
        end
      end
      ST_CHK: begin
        if (!status_i.at_last) begin
          cmd_o.chk_acc = 1'b1;
          cmd_o.rd_next = 1'b1;
        end else if (!status_i.chk_ok) begin
          cmd_o.head_inc = 1'b1;
          cmd_o.rd_start = 1'b1;
          state_d        = ST_SCAN;
        end else if (status_i.over_limit) begin
          state_d = ST_FLUSH;
        end else if (status_i.pend_valid) begin
          state_d = ST_PEND;
        end else begin
          cmd_o.rd_start = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      // The check byte of the previous frame goes out only now that it is
      // known not to close the run.
      ST_PEND: begin
        if (status_i.out_free) begin
          cmd_o.pend_out = 1'b1;
          cmd_o.rd_start = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.at_last) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.head_add  = 1'b1;
          cmd_o.rd_start  = 1'b1;
          state_d         = ST_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.rd_next  = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd_o.rd_start = 1'b1;
        if (!status_i.pend_valid) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.pend_out  = 1'b1;
          cmd_o.pend_last = 1'b1;
          cmd_o.commit    = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: design/xor_checksum_packet_deframer_core.sv
// Byte-serial frame hunter. Each received byte is appended to a ring buffer of BUF_DEPTH
// bytes, which is then scanned from its front for frames of source, length, destination,
// data and an XOR check byte; a candidate start failing the length, source, destination or
// check test is given up one byte at a time, and a passing frame is delivered one beat per
// byte and removed. A byte is taken only while the block is idle. The scan reads the
// buffer through its single read port, one byte a cycle while the output is not stalled:
// after a byte is taken the block stays busy until the scan stops at too few bytes, at an
// incomplete frame or at the result limit, examining each candidate start, checking each
// frame whose header passes, delivering each frame byte, releasing the held check byte
// before every frame after the first in the run and waiting out any output stall. The
// run_end flag marks the last beat caused by one byte. The buffer needs no clearing after reset.
module xor_checksum_packet_deframer_core #(
  parameter int unsigned BUF_DEPTH       = xcpd_pkg::BUF_DEPTH_DEF,
  parameter int unsigned MIN_FRAME_BYTES = xcpd_pkg::MIN_FRAME_BYTES_DEF,
  parameter int unsigned DEVICE_SLOTS    = xcpd_pkg::DEVICE_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [xcpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [xcpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [xcpd_pkg::BYTE_W-1:0]     rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [xcpd_pkg::BYTE_W-1:0]     frame_byte_o,
  output logic [xcpd_pkg::POS_W-1:0]      byte_position_o,
  output logic                            frame_end_o,
  output logic                            run_end_o
);
  import xcpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  xcpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  xcpd_datapath #(
    .BUF_DEPTH       (BUF_DEPTH),
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES),
    .DEVICE_SLOTS    (DEVICE_SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .frame_byte_o    (frame_byte_o),
    .byte_position_o (byte_position_o),
    .frame_end_o     (frame_end_o),
    .run_end_o       (run_end_o)
  );

endmodule

// File: design/xcpd_checker.sv
module xcpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [xcpd_pkg::BYTE_W-1:0] frame_byte_o,
  input logic [xcpd_pkg::POS_W-1:0]  byte_position_o,
  input logic                        frame_end_o,
  input logic                        run_end_o
);
  import xcpd_pkg::*;

  // Position the next delivered beat must carry.
  logic [POS_W-1:0] exp_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_pos_q <= frame_end_o ? '0 : byte_position_o + POS_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_byte_o) &&
      $stable(byte_position_o) && $stable(frame_end_o) && $stable(run_end_o))
    else $error("output beat changed while stalled");

  a_pos_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_position_o == exp_pos_q)
    else $error("byte position out of sequence");

  a_run_on_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_end_o |-> frame_end_o)
    else $error("run closed on a beat that is not a check byte");

  a_no_take_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_end_o |-> !in_ready_o)
    else $error("new byte offered before the run was complete");

endmodule

bind xor_checksum_packet_deframer_core xcpd_checker u_checker (.*);

// File: dv/xor_checksum_packet_deframer_core_tb.sv
`timescale 1ns / 100ps

module xor_checksum_packet_deframer_core_tb;
  import xcpd_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  // Long enough for the longest scan after one byte, through every candidate start with its
  // check and up to 64 beats.
  localparam int unsigned SETTLE_CYCLES   = 6000;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;
  localparam int unsigned SEGMENTS        = 8;
  localparam int unsigned SEGMENT_BYTES   = 45;
  localparam int unsigned MAX_FIT_LEN     = BUF_DEPTH_DEF - 2;
  localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;

  typedef enum int unsigned {
    INTACT,
    FLIPPED,
    TRUNCATED
  } damage_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              frame_last;
    logic              run_last;
  } beat_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0]     hunt_buf [BUF_DEPTH_DEF];
    int unsigned           fill;
    logic [LEN_W-1:0]      min_len;
    logic [LEN_W-1:0]      max_len;
    logic [TABLE_W-1:0]    dev_lo;
    logic [TABLE_W-1:0]    dev_hi;
    logic [SLOT_CNT_W-1:0] dst_slots;
    logic [SLOT_CNT_W-1:0] src_slots;
    beat_t                 expected_q[$];
    int unsigned           errors;
    int unsigned           bytes_in;
    int unsigned           beats_out;
    int unsigned           frames_out;

    function new();
      fill       = 0;
      min_len    = MIN_LEN_RST;
      max_len    = MAX_LEN_RST;
      dev_lo     = TABLE_RST;
      dev_hi     = TABLE_RST;
      dst_slots  = SLOT_CNT_RST;
      src_slots  = SLOT_CNT_RST;
      errors     = 0;
      bytes_in   = 0;
      beats_out  = 0;
      frames_out = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MIN_LEN:   min_len = val[LEN_W-1:0];
        CFG_MAX_LEN:   max_len = val[LEN_W-1:0];
        CFG_TABLE_LO:  dev_lo = val;
        CFG_TABLE_HI:  dev_hi = val;
        CFG_DST_SLOTS: dst_slots = val[SLOT_CNT_W-1:0];
        CFG_SRC_SLOTS: src_slots = val[SLOT_CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [BYTE_W-1:0] slot_addr(int unsigned slot);
      if (slot < 8) return dev_lo[8*slot +: 8];
      return dev_hi[8*(slot-8) +: 8];
    endfunction

    function bit addr_listed(logic [BYTE_W-1:0] addr, logic [SLOT_CNT_W-1:0] cnt);
      int unsigned lim;
      lim = (cnt > DEVICE_SLOTS_DEF) ? DEVICE_SLOTS_DEF : cnt;
      for (int unsigned s = 0; s < lim; s++) begin
        if (slot_addr(s) == addr) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Appends one received byte, rescans the buffer from its front and queues the beats
    // of every frame found.
    function void note_byte(logic [BYTE_W-1:0] b);
      int unsigned head;
      int unsigned n;
      int unsigned psize;
      logic [BYTE_W-1:0] plen;
      logic [BYTE_W-1:0] chk;
      beat_t one;
      head = 0;
      n = 0;
      bytes_in++;
      if (fill < BUF_DEPTH_DEF) begin
        hunt_buf[fill] = b;
        fill++;
      end
      while (fill - head >= MIN_FRAME_BYTES_DEF) begin
        plen = hunt_buf[head+1];
        psize = plen + 2;
        if (plen < min_len || plen > max_len || psize > BUF_DEPTH_DEF) begin
          head++;
          continue;
        end
        if (!addr_listed(hunt_buf[head], src_slots) ||
            !addr_listed(hunt_buf[head+2], dst_slots)) begin
          head++;
          continue;
        end
        if (fill - head < psize) break;
        chk = CHK_INIT;
        for (int unsigned k = 0; k + 1 < psize; k++) chk ^= hunt_buf[head+k];
        if (chk != hunt_buf[head+psize-1]) begin
          head++;
          continue;
        end
        if (n + psize > MAX_RESULTS) break;
        for (int unsigned k = 0; k < psize; k++) begin
          one.data       = hunt_buf[head+k];
          one.pos        = k[POS_W-1:0];
          one.frame_last = (k + 1 == psize);
          one.run_last   = 1'b0;
          expected_q.push_back(one);
        end
        n += psize;
        head += psize;
      end
      if (head > 0) begin
        for (int unsigned k = 0; k < fill - head; k++) hunt_buf[k] = hunt_buf[head+k];
        fill -= head;
      end
      if (n > 0) expected_q[expected_q.size()-1].run_last = 1'b1;
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      beats_out++;
      if (got.frame_last) frames_out++;
      if (expected_q.size() == 0) begin
        $error("unexpected beat: frame_byte %0h byte_position %0d", got.data, got.pos);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.data !== want.data) begin
        $error("frame_byte: expected %0h, got %0h", want.data, got.data);
        errors++;
      end
      if (got.pos !== want.pos) begin
        $error("byte_position: expected %0d, got %0d", want.pos, got.pos);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_end: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_end: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [BYTE_W-1:0]     rx_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [BYTE_W-1:0]     frame_byte_o;
  logic [POS_W-1:0]      byte_position_o;
  logic                  frame_end_o;
  logic                  run_end_o;

  int unsigned       idle_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       long_hold = 0;
  int unsigned       settings_used = 0;
  longint unsigned   cycle_count = 0;
  logic [BYTE_W-1:0] burst_q[$];
  frame_scoreboard   sb;

  xor_checksum_packet_deframer_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .rx_byte_i,
    .out_valid_o,
    .out_ready_i,
    .frame_byte_o,
    .byte_position_o,
    .frame_end_o,
    .run_end_o
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver counts a long hold-off down on its own, otherwise it stalls at random.
  always @(negedge clk_i) begin
    if (long_hold != 0) begin
      out_ready_i = 1'b0;
      long_hold--;
    end else begin
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_beat({frame_byte_o, byte_position_o, frame_end_o, run_end_o});
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic program_all(int unsigned lo_len, int unsigned hi_len,
                             logic [TABLE_W-1:0] lo, logic [TABLE_W-1:0] hi,
                             int unsigned dst, int unsigned src);
    write_reg(CFG_MIN_LEN, lo_len);
    write_reg(CFG_MAX_LEN, hi_len);
    write_reg(CFG_TABLE_LO, lo);
    write_reg(CFG_TABLE_HI, hi);
    write_reg(CFG_DST_SLOTS, dst);
    write_reg(CFG_SRC_SLOTS, src);
    settings_used++;
  endtask

  // A byte may leave no beat behind it, so the scan it started is given time to finish too.
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_burst();
    logic [BYTE_W-1:0] b;
    while (burst_q.size() != 0) begin
      b = burst_q.pop_front();
      if ($urandom_range(99) < idle_pct) begin
        in_valid_i = 1'b0;
        do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
      end
      in_valid_i = 1'b1;
      rx_byte_i  = b;
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_byte(b);
      @(negedge clk_i);
    end
    in_valid_i = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_addr(logic [SLOT_CNT_W-1:0] cnt);
    int unsigned lim;
    lim = (cnt > DEVICE_SLOTS_DEF) ? DEVICE_SLOTS_DEF : cnt;
    if (lim == 0) return 8'($urandom);
    return sb.slot_addr($urandom_range(lim - 1));
  endfunction

  // Most lengths sit near the lower bound; wide picks span the whole accepted range.
  function automatic int unsigned pick_len(bit wide);
    int unsigned lo;
    int unsigned hi;
    lo = sb.min_len;
    hi = (sb.max_len > MAX_FIT_LEN) ? MAX_FIT_LEN : sb.max_len;
    if (lo > hi) return lo;
    if (!wide && $urandom_range(7) != 0 && hi > lo + 6) hi = lo + 6;
    return $urandom_range(hi, lo);
  endfunction

  function automatic void add_frame(int unsigned len, damage_e damage);
    logic [BYTE_W-1:0] bytes_q[$];
    logic [BYTE_W-1:0] chk;
    int unsigned k;
    bytes_q.push_back(pick_addr(sb.src_slots));
    bytes_q.push_back(8'(len));
    bytes_q.push_back(pick_addr(sb.dst_slots));
    repeat (len - 2) bytes_q.push_back(8'($urandom));
    chk = CHK_INIT;
    foreach (bytes_q[i]) chk ^= bytes_q[i];
    bytes_q.push_back(chk);
    case (damage)
      FLIPPED: begin
        k = $urandom_range(bytes_q.size() - 1);
        bytes_q[k] ^= 8'($urandom_range(255, 1));
      end
      TRUNCATED: repeat ($urandom_range(bytes_q.size() - 1, 1)) void'(bytes_q.pop_back());
      default: ;
    endcase
    foreach (bytes_q[i]) burst_q.push_back(bytes_q[i]);
  endfunction

  task automatic setup_segment(int unsigned seg);
    logic [TABLE_W-1:0] lo;
    logic [TABLE_W-1:0] hi;
    int unsigned mn;
    int unsigned mx;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case (seg % 4)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 68;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 68;
      end
      default: begin
        idle_pct  = 12;
        stall_pct = 12;
      end
    endcase
    case (seg)
      0, 7: program_all(3, 62, lo, hi, 16, 16);
      1: program_all(3, 3, lo, hi, 1, 1);
      2: program_all(62, 62, lo, hi, 16, 2);
      3: begin
        mn = $urandom_range(10, 3);
        mx = $urandom_range(30, mn);
        program_all(mn, mx, lo, hi, $urandom_range(16, 1), $urandom_range(16, 1));
      end
      4: program_all(3, 63, lo, hi, 17, 31);
      // Only four distinct addresses, so the table holds many repeats.
      5: program_all(3, 12, lo & {8{8'h03}}, hi & {8{8'h03}},
                     $urandom_range(31, 1), $urandom_range(31, 1));
      default: program_all(5, 20, lo, hi, 16, 8);
    endcase
  endtask

  task automatic random_segment();
    int unsigned fed;
    int unsigned roll;
    fed = 0;
    while (fed < SEGMENT_BYTES) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        add_frame(pick_len(1'b0), INTACT);
      end else if (roll < 72) begin
        add_frame(pick_len(1'b0), FLIPPED);
      end else if (roll < 79) begin
        add_frame(pick_len(1'b0), TRUNCATED);
      end else if (roll < 88) begin
        repeat ($urandom_range(4, 1)) burst_q.push_back(8'($urandom));
      end else begin
        // A plausible header with a long length hides the frames behind it until its
        // check finally fails.
        burst_q.push_back(pick_addr(sb.src_slots));
        burst_q.push_back(8'(pick_len(1'b1)));
        burst_q.push_back(pick_addr(sb.dst_slots));
        repeat ($urandom_range(2, 1)) add_frame(pick_len(1'b0), INTACT);
      end
      fed += burst_q.size();
      send_burst();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Source slot count above the table size, and the largest length, which cannot fit.
    program_all(3, 63, 64'h7F6E_5D4C_3B2A_1900, 64'hFFEE_DDCC_BBAA_9980, 16, 31);
    burst_q = '{8'hFF, 8'h03, 8'h00, 8'hFF, 8'h03,
                8'h2A, 8'h3F, 8'h19, 8'h00, 8'h00,
                8'h19, 8'h04, 8'h80, 8'h00, 8'h00, 8'h9C};
    send_burst();
    settle();

    // No destination slot at all: a well-formed frame must be dropped.
    write_reg(CFG_DST_SLOTS, '0);
    settings_used++;
    burst_q = '{8'h00, 8'h03, 8'hFF, 8'h5A, 8'hA6};
    send_burst();
    settle();

    // Inverted length range with a length between the two bounds.
    write_reg(CFG_DST_SLOTS, 16);
    write_reg(CFG_MIN_LEN, 40);
    write_reg(CFG_MAX_LEN, 10);
    settings_used++;
    burst_q = '{8'h00, 8'h19, 8'hFF, 8'h5A, 8'hA6};
    send_burst();
    settle();

    // The receiver holds off while frames keep coming, so the input backs up.
    setup_segment(0);
    @(posedge clk_i);
    long_hold = HOLD_OFF_CYCLES;
    @(negedge clk_i);
    repeat (4) add_frame(pick_len(1'b0), INTACT);
    send_burst();
    settle();

    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      setup_segment(seg);
      random_segment();
      settle();
    end

    $display("Fed %0d bytes under %0d register settings; %0d frames in %0d beats checked.",
             sb.bytes_in, settings_used, sb.frames_out, sb.beats_out);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/xcpd_pkg.sv
design/xcpd_datapath.sv
design/xcpd_ctrl.sv
design/xor_checksum_packet_deframer_core.sv
design/xcpd_checker.sv
dv/xor_checksum_packet_deframer_core_tb.sv
